// ===== rtl/rtyc_pkg.sv =====
package rtyc_pkg;

  localparam int BLOCK_SIZE = 8;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SIZE_W     = 13;
  localparam int CNT_W      = 14;
  localparam int PROD_W     = 26;
  localparam int SUM_W      = 27;
  localparam int PIX_W      = 16;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd8;

  localparam logic signed [17:0] KY_R  = 18'sd19595;
  localparam logic signed [17:0] KY_G  = 18'sd38470;
  localparam logic signed [17:0] KY_B  = 18'sd7471;
  localparam logic signed [17:0] KCB_R = -18'sd11056;
  localparam logic signed [17:0] KCB_G = -18'sd21712;
  localparam logic signed [17:0] KCB_B = 18'sd32768;
  localparam logic signed [17:0] KCR_R = 18'sd32768;
  localparam logic signed [17:0] KCR_G = -18'sd27440;
  localparam logic signed [17:0] KCR_B = -18'sd5328;

  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 27'sd8388608;
  localparam logic signed [SUM_W-1:0] ROUND_HALF    = 27'sd128;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [SIZE_W-1:0] row0;
    logic [SIZE_W-1:0] col0;
    logic [CNT_W-1:0]  row_end;
    logic [CNT_W-1:0]  col_end;
    logic              last_row;
    logic              last_col;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    geom_t            geom;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic prod_t mul_coef(logic signed [17:0] k, logic [7:0] x);
    logic signed [26:0] p;
    p = k * $signed({1'b0, x});
    return PROD_W'(p);
  endfunction

  function automatic logic [PIX_W-1:0] round_sum(prod_t a, prod_t b, prod_t c,
                                                 logic signed [SUM_W-1:0] off);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + off + ROUND_HALF;
    return s[PIX_W+7:8];
  endfunction

  function automatic logic [CNT_W-1:0] pad_up(logic [SIZE_W-1:0] n);
    logic [CNT_W-1:0] t;
    t = CNT_W'(n) + CNT_W'(BLOCK_SIZE - 1);
    return t & ~CNT_W'(BLOCK_SIZE - 1);
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > 32'(maxv)) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rtyc_front.sv =====
module rtyc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_red,
  input  logic [7:0]                         in_green,
  input  logic [7:0]                         in_blue,
  input  logic                               cfg_we,
  input  logic [rtyc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtyc_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                               q_push,
  output rtyc_pkg::entry_t                   q_data,
  input  rtyc_pkg::qstat_t                   q_stat
);

  logic [rtyc_pkg::SIZE_W-1:0] width_r, width_nxt;
  logic [rtyc_pkg::SIZE_W-1:0] height_r, height_nxt;
  logic [rtyc_pkg::SIZE_W-1:0] col_r, col_nxt;
  logic [rtyc_pkg::SIZE_W-1:0] row_r, row_nxt;
  logic                        a_valid_r, a_valid_nxt;
  rtyc_pkg::prod_t             a_prod_r [9];
  rtyc_pkg::geom_t             a_geom_r;
  rtyc_pkg::geom_t             geom;
  logic                        accept;
  logic                        size_write;

  assign in_ready = !a_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = a_valid_r && !q_stat.full;
  assign size_write = cfg_we && (cfg_index == rtyc_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == rtyc_pkg::REG_IMAGE_HEIGHT);

  always_comb begin
    geom.row0     = row_r;
    geom.col0     = col_r;
    geom.last_col = (rtyc_pkg::CNT_W'(col_r) + 14'd1) >= rtyc_pkg::CNT_W'(width_r);
    geom.last_row = (rtyc_pkg::CNT_W'(row_r) + 14'd1) >= rtyc_pkg::CNT_W'(height_r);
    geom.col_end  = geom.last_col ? rtyc_pkg::pad_up(width_r)
                                  : rtyc_pkg::CNT_W'(col_r) + 14'd1;
    geom.row_end  = geom.last_row ? rtyc_pkg::pad_up(height_r)
                                  : rtyc_pkg::CNT_W'(row_r) + 14'd1;
  end

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
    if (size_write) begin
      if (cfg_index == rtyc_pkg::REG_IMAGE_WIDTH) begin
        width_nxt = rtyc_pkg::clamp_size(cfg_wdata, rtyc_pkg::MAX_WIDTH);
      end else begin
        height_nxt = rtyc_pkg::clamp_size(cfg_wdata, rtyc_pkg::MAX_HEIGHT);
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (geom.last_col) begin
        col_nxt = '0;
        row_nxt = geom.last_row ? '0 : row_r + 13'd1;
      end else begin
        col_nxt = col_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rtyc_pkg::SIZE_RESET;
      height_r  <= rtyc_pkg::SIZE_RESET;
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_prod_r[0] <= rtyc_pkg::mul_coef(rtyc_pkg::KY_R, in_red);
      a_prod_r[1] <= rtyc_pkg::mul_coef(rtyc_pkg::KY_G, in_green);
      a_prod_r[2] <= rtyc_pkg::mul_coef(rtyc_pkg::KY_B, in_blue);
      a_prod_r[3] <= rtyc_pkg::mul_coef(rtyc_pkg::KCB_R, in_red);
      a_prod_r[4] <= rtyc_pkg::mul_coef(rtyc_pkg::KCB_G, in_green);
      a_prod_r[5] <= rtyc_pkg::mul_coef(rtyc_pkg::KCB_B, in_blue);
      a_prod_r[6] <= rtyc_pkg::mul_coef(rtyc_pkg::KCR_R, in_red);
      a_prod_r[7] <= rtyc_pkg::mul_coef(rtyc_pkg::KCR_G, in_green);
      a_prod_r[8] <= rtyc_pkg::mul_coef(rtyc_pkg::KCR_B, in_blue);
      a_geom_r    <= geom;
    end
  end

  always_comb begin
    q_data.luma        = rtyc_pkg::round_sum(a_prod_r[0], a_prod_r[1], a_prod_r[2], '0);
    q_data.chroma_blue = rtyc_pkg::round_sum(a_prod_r[3], a_prod_r[4], a_prod_r[5],
                                             rtyc_pkg::CHROMA_OFFSET);
    q_data.chroma_red  = rtyc_pkg::round_sum(a_prod_r[6], a_prod_r[7], a_prod_r[8],
                                             rtyc_pkg::CHROMA_OFFSET);
    q_data.geom        = a_geom_r;
  end

endmodule

// ===== rtl/rtyc_fifo.sv =====
module rtyc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rtyc_pkg::entry_t wr_data,
  input  logic             pop,
  output rtyc_pkg::entry_t rd_data,
  output rtyc_pkg::qstat_t stat
);

  rtyc_pkg::entry_t             mem_r [rtyc_pkg::QDEPTH];
  logic [rtyc_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rtyc_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rtyc_pkg::QAW:0]       count_r, count_nxt;

  assign stat.full  = count_r == (rtyc_pkg::QAW+1)'(rtyc_pkg::QDEPTH);
  assign stat.empty = count_r == '0;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/rtyc_back.sv =====
module rtyc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtyc_pkg::entry_t              q_head,
  input  rtyc_pkg::qstat_t              q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtyc_pkg::PIX_W-1:0]    out_luma,
  output logic [rtyc_pkg::PIX_W-1:0]    out_chroma_blue,
  output logic [rtyc_pkg::PIX_W-1:0]    out_chroma_red,
  output logic [rtyc_pkg::IDX_W-1:0]    out_row,
  output logic [rtyc_pkg::IDX_W-1:0]    out_col,
  output logic                          out_last_of_pixel,
  output logic                          out_image_done
);

  logic                        out_valid_r, out_valid_nxt;
  rtyc_pkg::entry_t            cur_r;
  logic [rtyc_pkg::CNT_W-1:0]  rr_r, rr_nxt;
  logic [rtyc_pkg::CNT_W-1:0]  cc_r, cc_nxt;
  logic                        row_wrap;
  logic                        final_res;
  logic                        load;
  logic                        step;

  assign row_wrap  = (cc_r + 14'd1) == cur_r.geom.col_end;
  assign final_res = row_wrap && ((rr_r + 14'd1) == cur_r.geom.row_end);
  assign load      = !q_stat.empty && (!out_valid_r || (out_ready && final_res));
  assign step      = out_valid_r && out_ready;
  assign q_pop     = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    rr_nxt        = rr_r;
    cc_nxt        = cc_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      rr_nxt        = rtyc_pkg::CNT_W'(q_head.geom.row0);
      cc_nxt        = rtyc_pkg::CNT_W'(q_head.geom.col0);
    end else if (step && final_res) begin
      out_valid_nxt = 1'b0;
    end else if (step) begin
      if (row_wrap) begin
        cc_nxt = rtyc_pkg::CNT_W'(cur_r.geom.col0);
        rr_nxt = rr_r + 14'd1;
      end else begin
        cc_nxt = cc_r + 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= rr_nxt;
    cc_r <= cc_nxt;
    if (load) begin
      cur_r <= q_head;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_luma          = cur_r.luma;
  assign out_chroma_blue   = cur_r.chroma_blue;
  assign out_chroma_red    = cur_r.chroma_red;
  assign out_row           = rr_r[rtyc_pkg::IDX_W-1:0];
  assign out_col           = cc_r[rtyc_pkg::IDX_W-1:0];
  assign out_last_of_pixel = final_res;
  assign out_image_done    = final_res && cur_r.geom.last_row && cur_r.geom.last_col;

endmodule

// ===== rtl/rgb_to_ycbcr_edge_pad_core.sv =====
// A pixel's products are registered, written into the queue, then loaded into the
// output stage. Throughput: one result per cycle while out_ready is high; a pixel
// causes 1 to 64 results, set by the output stage stepping row and column.
// A 4-entry queue between the converter and the output stage absorbs padding bursts.
// Reset (synchronous, rst_n low): size 8 x 8, input position counters zero, queue empty.
module rgb_to_ycbcr_edge_pad_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rtyc_pkg::PIX_W-1:0]     out_luma,
  output logic [rtyc_pkg::PIX_W-1:0]     out_chroma_blue,
  output logic [rtyc_pkg::PIX_W-1:0]     out_chroma_red,
  output logic [rtyc_pkg::IDX_W-1:0]     out_row,
  output logic [rtyc_pkg::IDX_W-1:0]     out_col,
  output logic                           out_last_of_pixel,
  output logic                           out_image_done,
  input  logic                           cfg_we,
  input  logic [rtyc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtyc_pkg::SIZE_W-1:0]    cfg_wdata
);

  logic             q_push;
  logic             q_pop;
  rtyc_pkg::entry_t q_wr;
  rtyc_pkg::entry_t q_head;
  rtyc_pkg::qstat_t q_stat;

  rtyc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_wr),
    .q_stat    (q_stat)
  );

  rtyc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  rtyc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_luma          (out_luma),
    .out_chroma_blue   (out_chroma_blue),
    .out_chroma_red    (out_chroma_red),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_pixel (out_last_of_pixel),
    .out_image_done    (out_image_done)
  );

endmodule
